// File: src/assert_macros.svh
// Assertion macros shared by the priority mux RTL.
// No dependencies; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PMT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("check failed");
`define PMT_ASSERT_NR(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error("check failed");
`else
`define PMT_ASSERT(lbl, prop)
`define PMT_ASSERT_NR(lbl, prop)
`endif
`endif

// File: src/pmt_pkg.sv
// Package for the priority source mux with timeout: constants, request and
// result types, and helpers for register field extraction. No dependencies.
package pmt_pkg;

  localparam int NUM_SOURCES  = 8;
  localparam int TIMEOUT_BITS = 16;

  localparam int CntW   = (TIMEOUT_BITS < 16) ? TIMEOUT_BITS : 16;
  localparam int GlbW   = CntW + 1;
  localparam int QDepth = 2;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = QPtrW + 1;

  typedef enum logic [1:0] {
    CFG_SOURCES   = 2'd0,
    CFG_PRIORITY  = 2'd1,
    CFG_TIMEO_LOW = 2'd2,
    CFG_TIMEO_HI  = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    KIND_CMD    = 2'd0,
    KIND_TICK   = 2'd1,
    KIND_REJECT = 2'd2
  } kind_e;

  localparam logic OP_COMMAND = 1'b0;

  typedef struct packed {
    logic        opcode;
    logic [2:0]  source_index;
    logic [63:0] command_word;
  } in_item_t;

  typedef struct packed {
    logic        forward_valid;
    logic [63:0] forward_word;
    logic        owner_changed;
    logic        idle_announced;
    logic [2:0]  owner_index;
    logic        owner_vacant;
    logic        global_dislodge;
    logic [7:0]  active_mask;
    logic        input_rejected;
  } out_item_t;

  typedef struct packed {
    kind_e       kind;
    logic [2:0]  idx;
    logic [63:0] word;
  } req_t;

  typedef struct packed {
    logic [63:0] prio;
    logic [63:0] timeo_lo;
    logic [63:0] timeo_hi;
    logic [3:0]  used;
  } cfg_t;

  function automatic logic [CntW-1:0] timeout_of(logic [63:0] lo, logic [63:0] hi,
                                                 logic [2:0] i);
    logic [63:0] r;
    r = i[2] ? hi : lo;
    return r[16*i[1:0] +: CntW];
  endfunction

  function automatic logic [7:0] prio_of(logic [63:0] tbl, logic [2:0] i);
    return tbl[8*i +: 8];
  endfunction

endpackage

// File: src/pmt_front.sv
// Front end: accepts requests and classifies them as command, tick or reject.
// Depends on pmt_pkg.
module pmt_front (
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  pmt_pkg::in_item_t in_req_i,
  input  logic [3:0]      used_i,
  input  logic            q_full_i,
  output logic            q_push_o,
  output pmt_pkg::req_t   q_req_o
);

  localparam logic [3:0] NumSrc = 4'(pmt_pkg::NUM_SOURCES);

  logic [3:0] used;

  assign used       = (used_i > NumSrc) ? NumSrc : used_i;
  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  always_comb begin
    q_req_o.idx  = in_req_i.source_index;
    q_req_o.word = in_req_i.command_word;
    if (in_req_i.opcode != pmt_pkg::OP_COMMAND) begin
      q_req_o.kind = pmt_pkg::KIND_TICK;
    end else if ({1'b0, in_req_i.source_index} >= used) begin
      q_req_o.kind = pmt_pkg::KIND_REJECT;
    end else begin
      q_req_o.kind = pmt_pkg::KIND_CMD;
    end
  end

endmodule

// File: src/pmt_queue.sv
// Short request queue between front and back ends.
// Depends on pmt_pkg and assert_macros.svh.
`include "assert_macros.svh"
module pmt_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  pmt_pkg::req_t push_req_i,
  input  logic          pop_i,
  output pmt_pkg::req_t head_o,
  output logic          empty_o,
  output logic          full_o
);

  pmt_pkg::req_t                   mem_q [pmt_pkg::QDepth];
  logic [pmt_pkg::QPtrW-1:0]       wr_q, wr_d, rd_q, rd_d;
  logic [pmt_pkg::QCntW-1:0]       cnt_q, cnt_d;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == pmt_pkg::QCntW'(pmt_pkg::QDepth));
  assign head_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? wr_q + 1'b1 : wr_q;
    rd_d  = pop_i ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + pmt_pkg::QCntW'(push_i) - pmt_pkg::QCntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_req_i;
    end
  end

  `PMT_ASSERT_NR(a_cnt_bound, cnt_q <= pmt_pkg::QCntW'(pmt_pkg::QDepth))
  `PMT_ASSERT(a_no_overflow, !(push_i && full_o))
  `PMT_ASSERT(a_no_underflow, !(pop_i && empty_o))

endmodule

// File: src/pmt_back.sv
// Back end: owner arbitration, source and global timers, result register.
// Depends on pmt_pkg and assert_macros.svh.
`include "assert_macros.svh"
module pmt_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pmt_pkg::cfg_t     cfg_i,
  input  logic              q_empty_i,
  input  pmt_pkg::req_t     q_head_i,
  output logic              q_pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output pmt_pkg::out_item_t out_res_o
);

  localparam int N = pmt_pkg::NUM_SOURCES;
  localparam logic [3:0] NumSrc = 4'(N);

  logic [pmt_pkg::CntW-1:0] cnt_q [N];
  logic [pmt_pkg::CntW-1:0] cnt_d [N];
  logic [N-1:0]             run_q, run_d, act_q, act_d;
  logic [pmt_pkg::GlbW-1:0] glb_q, glb_d;
  logic                     grun_q, grun_d;
  logic [2:0]               own_q, own_d;
  logic                     vac_q, vac_d;
  logic                     out_valid_q;
  pmt_pkg::out_item_t       out_q, res;
  logic [3:0]               used;
  logic [pmt_pkg::CntW-1:0] longest, t;
  logic                     fwd;

  assign used        = (cfg_i.used > NumSrc) ? NumSrc : cfg_i.used;
  assign q_pop_o     = !q_empty_i && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

  always_comb begin
    longest = '0;
    for (int i = 0; i < N; i++) begin
      t = pmt_pkg::timeout_of(cfg_i.timeo_lo, cfg_i.timeo_hi, 3'(i));
      if ((4'(i) < used) && (t > longest)) begin
        longest = t;
      end
    end
  end

  always_comb begin
    cnt_d  = cnt_q;
    run_d  = run_q;
    act_d  = act_q;
    glb_d  = glb_q;
    grun_d = grun_q;
    own_d  = own_q;
    vac_d  = vac_q;
    res    = '0;
    fwd    = 1'b0;
    case (q_head_i.kind)
      pmt_pkg::KIND_CMD: begin
        glb_d  = {1'b0, longest} << 1;
        grun_d = 1'b1;
        for (int i = 0; i < N; i++) begin
          if (q_head_i.idx == 3'(i)) begin
            cnt_d[i] = pmt_pkg::timeout_of(cfg_i.timeo_lo, cfg_i.timeo_hi, q_head_i.idx);
            run_d[i] = 1'b1;
            act_d[i] = 1'b1;
          end
        end
        fwd = vac_q || (own_q == q_head_i.idx) ||
              (pmt_pkg::prio_of(cfg_i.prio, q_head_i.idx) >
               pmt_pkg::prio_of(cfg_i.prio, own_q));
        if (fwd) begin
          if (vac_q || (own_q != q_head_i.idx)) begin
            own_d             = q_head_i.idx;
            vac_d             = 1'b0;
            res.owner_changed = 1'b1;
          end
          res.forward_valid = 1'b1;
          res.forward_word  = q_head_i.word;
        end
      end
      pmt_pkg::KIND_TICK: begin
        for (int i = 0; i < N; i++) begin
          if (run_q[i]) begin
            if (cnt_q[i] <= pmt_pkg::CntW'(1)) begin
              cnt_d[i] = '0;
              run_d[i] = 1'b0;
              act_d[i] = 1'b0;
              if (!vac_q && (own_q == 3'(i))) begin
                vac_d              = 1'b1;
                own_d              = '0;
                res.idle_announced = 1'b1;
              end
            end else begin
              cnt_d[i] = cnt_q[i] - pmt_pkg::CntW'(1);
            end
          end
        end
        if (grun_q) begin
          if (glb_q <= pmt_pkg::GlbW'(1)) begin
            glb_d  = '0;
            grun_d = 1'b0;
            if (!vac_d) begin
              vac_d               = 1'b1;
              own_d               = '0;
              res.idle_announced  = 1'b1;
              res.global_dislodge = 1'b1;
            end
          end else begin
            glb_d = glb_q - pmt_pkg::GlbW'(1);
          end
        end
      end
      pmt_pkg::KIND_REJECT: begin
        res.input_rejected = 1'b1;
      end
      default: begin
        res.input_rejected = 1'b1;
      end
    endcase
    res.owner_index  = vac_d ? 3'd0 : own_d;
    res.owner_vacant = vac_d;
    res.active_mask  = 8'(act_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < N; i++) begin
        cnt_q[i] <= '0;
      end
      run_q       <= '0;
      act_q       <= '0;
      glb_q       <= '0;
      grun_q      <= 1'b0;
      own_q       <= '0;
      vac_q       <= 1'b1;
      out_valid_q <= 1'b0;
    end else if (q_pop_o) begin
      cnt_d_copy: for (int i = 0; i < N; i++) begin
        cnt_q[i] <= cnt_d[i];
      end
      run_q       <= run_d;
      act_q       <= act_d;
      glb_q       <= glb_d;
      grun_q      <= grun_d;
      own_q       <= own_d;
      vac_q       <= vac_d;
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      out_q <= res;
    end
  end

  `PMT_ASSERT(a_vacant_owner_zero, vac_q |-> (own_q == 3'd0))
  `PMT_ASSERT(a_fwd_not_idle, out_valid_q |-> !(out_q.forward_valid && out_q.idle_announced))
  `PMT_ASSERT(a_dislodge_idle,
              (out_valid_q && out_q.global_dislodge) |->
              (out_q.idle_announced && out_q.owner_vacant))

endmodule

// File: src/priority_source_mux_with_timeout_top.sv
// Sustained rate is one request per clock cycle, commands and ticks alike,
// while results are being taken. An accepted request is held in the two-entry
// request queue, then the back end registers its result in the output register.
// Input ready drops only when that queue is full because results are not being
// taken. Configuration writes take effect on the next cycle and must be issued
// only while no request is in flight. Depends on pmt_pkg, pmt_front, pmt_queue,
// pmt_back.
module priority_source_mux_with_timeout_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [63:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  pmt_pkg::in_item_t  in_req_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output pmt_pkg::out_item_t out_res_o
);

  pmt_pkg::cfg_t cfg_q;
  pmt_pkg::req_t push_req, head;
  logic          push, pop, q_empty, q_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (pmt_pkg::cfg_reg_e'(cfg_idx_i))
        pmt_pkg::CFG_SOURCES:   cfg_q.used     <= cfg_data_i[3:0];
        pmt_pkg::CFG_PRIORITY:  cfg_q.prio     <= cfg_data_i;
        pmt_pkg::CFG_TIMEO_LOW: cfg_q.timeo_lo <= cfg_data_i;
        pmt_pkg::CFG_TIMEO_HI:  cfg_q.timeo_hi <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  pmt_front u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .used_i     (cfg_q.used),
    .q_full_i   (q_full),
    .q_push_o   (push),
    .q_req_o    (push_req)
  );

  pmt_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_req_i (push_req),
    .pop_i      (pop),
    .head_o     (head),
    .empty_o    (q_empty),
    .full_o     (q_full)
  );

  pmt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_empty_i   (q_empty),
    .q_head_i    (head),
    .q_pop_o     (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_res_o   (out_res_o)
  );

endmodule
